// ===== hw/rtl/trq_pkg.sv =====
package trq_pkg;

  localparam int NUM_TOPICS = 4;
  localparam int SLOTS = 8;
  localparam int TOTAL_SLOTS = NUM_TOPICS * SLOTS;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int TIDX_W = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;
  localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

  localparam int TAG_W = 32;
  localparam int NUM_W = 31;
  localparam int STAMP_W = 32;
  localparam int PUB_W = 16;
  localparam int PHOTO_W = 32;
  localparam int AGE_W = 16;
  localparam int TCOUNT_W = 3;
  localparam int CFG_W = 16;

  localparam logic [TAG_W-1:0] MARKER = '1;
  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  localparam logic REG_AGE_LIMIT = 1'b0;
  localparam logic REG_TOPIC_COUNT = 1'b1;

  localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 16'd5;
  localparam logic [TCOUNT_W-1:0] TOPIC_COUNT_RESET = 3'd3;

  typedef enum logic [1:0] {
    CMD_PUBLISH = 2'd0,
    CMD_GET = 2'd1,
    CMD_EXPIRE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE = 3'd0,
    ST_LATER = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FULL = 3'd3,
    ST_YOUNG = 3'd4,
    ST_NONE = 3'd5,
    ST_BADTOPIC = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_READ,
    S_FETCH,
    S_AGE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [PUB_W-1:0] publisher;
    logic [PHOTO_W-1:0] photo;
  } slot_data_t;

  function automatic logic [TAG_W-1:0] tag_reset(input int i);
    return ((i % SLOTS) == (SLOTS - 1)) ? MARKER : '0;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [TIDX_W-1:0] t,
                                                  input logic [SLOT_W-1:0] j);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(t) * ADDR_W'(SLOTS);
    return base + ADDR_W'(j);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] j);
    return (j == SLOT_W'(SLOTS - 1)) ? '0 : j + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] j);
    return (j == '0) ? SLOT_W'(SLOTS - 1) : j - 1'b1;
  endfunction

endpackage

// ===== hw/rtl/trq_slot_mem.sv =====
module trq_slot_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [trq_pkg::ADDR_W-1:0] waddr,
  input  trq_pkg::slot_data_t        wdata,
  input  logic                       re,
  input  logic [trq_pkg::ADDR_W-1:0] raddr,
  output trq_pkg::slot_data_t        rdata
);
  import trq_pkg::*;

  slot_data_t mem [TOTAL_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/topic_ring_queue_with_expiry_unit.sv =====
// Flow: a word is taken only in idle; publish, unused commands, a bad topic or an empty ring
// go from check to finish, expire passes through the age state, and get scans one slot tag
// per cycle, then reads and, on a hit, fetches before finish, which loads the output register
// once it is free. A new word is taken only after that, so words never overlap.
// Reset: synchronous, clears all tags to empty with a marker in each ring's last slot,
// head and tail to zero, the entry counter to one and the registers to their defaults.
module topic_ring_queue_with_expiry_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [trq_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   cmd,
  input  logic [1:0]                   topic,
  input  logic [trq_pkg::NUM_W-1:0]    seen_entry,
  input  logic [trq_pkg::PUB_W-1:0]    publisher_id,
  input  logic [trq_pkg::PHOTO_W-1:0]  photo_ref,
  input  logic [trq_pkg::STAMP_W-1:0]  now_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic [trq_pkg::NUM_W-1:0]    entry_num,
  output logic [trq_pkg::PUB_W-1:0]    publisher_out,
  output logic [trq_pkg::PHOTO_W-1:0]  photo_out,
  output logic [trq_pkg::STAMP_W-1:0]  stamp_out
);
  import trq_pkg::*;

  state_t state;
  state_t state_next;

  logic [AGE_W-1:0] age_limit;
  logic [TCOUNT_W-1:0] topic_count;

  logic [1:0] cmd_r;
  logic [1:0] topic_r;
  logic [NUM_W-1:0] last_r;
  logic [PUB_W-1:0] pub_r;
  logic [PHOTO_W-1:0] photo_r;
  logic [STAMP_W-1:0] now_r;

  logic [TAG_W-1:0] tags [TOTAL_SLOTS];
  logic [SLOT_W-1:0] head_idx [NUM_TOPICS];
  logic [SLOT_W-1:0] tail_idx [NUM_TOPICS];
  logic [NUM_W-1:0] next_number;

  logic [SLOT_W-1:0] scan_j;
  logic [SLOT_W-1:0] sel_j;
  logic hit;
  logic hit_exact;

  status_t res_status;
  logic [NUM_W-1:0] res_entry;
  logic [PUB_W-1:0] res_pub;
  logic [PHOTO_W-1:0] res_photo;
  logic [STAMP_W-1:0] res_stamp;

  logic [TIDX_W-1:0] tidx;
  logic [SLOT_W-1:0] head_cur;
  logic [SLOT_W-1:0] tail_cur;
  logic [ADDR_W-1:0] head_addr;
  logic [ADDR_W-1:0] prev_addr;
  logic [ADDR_W-1:0] tail_addr;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] sel_addr;
  logic [ADDR_W-1:0] tag_raddr;
  logic [TAG_W-1:0] tag_rd;
  logic topic_ok;
  logic ring_empty;
  logic ring_full;
  logic [TAG_W-1:0] target;
  logic tag_exact;
  logic tag_later;
  logic [STAMP_W-1:0] age;
  logic too_young;
  logic out_free;

  logic mem_we;
  logic mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  slot_data_t mem_wdata;
  slot_data_t mem_rdata;

  assign tidx = TIDX_W'(topic_r);
  assign head_cur = head_idx[tidx];
  assign tail_cur = tail_idx[tidx];
  assign head_addr = slot_addr(tidx, head_cur);
  assign prev_addr = slot_addr(tidx, slot_dec(head_cur));
  assign tail_addr = slot_addr(tidx, tail_cur);
  assign scan_addr = slot_addr(tidx, scan_j);
  assign sel_addr = slot_addr(tidx, sel_j);
  assign tag_rd = tags[tag_raddr];

  assign topic_ok = (TCOUNT_W'(topic_r) < topic_count) && (32'(topic_r) < NUM_TOPICS);
  assign ring_empty = (head_cur == tail_cur);
  assign ring_full = (tag_rd == MARKER);

  // The marker and any other tag with the top bit set compare as negative and never match.
  assign target = TAG_W'(last_r) + 1'b1;
  assign tag_exact = !tag_rd[TAG_W-1] && (tag_rd == target);
  assign tag_later = !tag_rd[TAG_W-1] && (tag_rd > target);

  assign age = now_r - mem_rdata.stamp;
  assign too_young = (age < STAMP_W'(age_limit));

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  assign mem_wdata.stamp = now_r;
  assign mem_wdata.publisher = pub_r;
  assign mem_wdata.photo = photo_r;

  trq_slot_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (topic_ok && !ring_empty && (cmd_r == CMD_GET)) begin
          state_next = S_SCAN;
        end else if (topic_ok && !ring_empty && (cmd_r == CMD_EXPIRE)) begin
          state_next = S_AGE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        if (tag_exact || (scan_j == SLOT_W'(SLOTS - 1))) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = hit ? S_FETCH : S_FINISH;
      end
      S_FETCH: state_next = S_FINISH;
      S_AGE: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    tag_raddr = tail_addr;
    mem_re = 1'b0;
    mem_we = 1'b0;
    mem_raddr = head_addr;
    case (state)
      S_CHECK: begin
        tag_raddr = tail_addr;
        mem_re = (cmd_r == CMD_EXPIRE);
        mem_we = topic_ok && (cmd_r == CMD_PUBLISH) && !ring_full;
      end
      S_SCAN: tag_raddr = scan_addr;
      S_READ: begin
        mem_re = hit;
        mem_raddr = sel_addr;
      end
      S_FETCH: tag_raddr = sel_addr;
      S_AGE: tag_raddr = head_addr;
      default: tag_raddr = tail_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= AGE_LIMIT_RESET;
      topic_count <= TOPIC_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AGE_LIMIT: age_limit <= cfg_data[AGE_W-1:0];
        REG_TOPIC_COUNT: topic_count <= cfg_data[TCOUNT_W-1:0];
        default: age_limit <= age_limit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_r <= cmd;
      topic_r <= topic;
      last_r <= seen_entry;
      pub_r <= publisher_id;
      photo_r <= photo_ref;
      now_r <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        tags[i] <= tag_reset(i);
      end
      for (int t = 0; t < NUM_TOPICS; t++) begin
        head_idx[t] <= '0;
        tail_idx[t] <= '0;
      end
      next_number <= NUM_W'(1);
    end else begin
      if (mem_we) begin
        tags[tail_addr] <= TAG_W'(next_number);
        tail_idx[tidx] <= slot_inc(tail_cur);
        if (next_number != NUM_MAX) begin
          next_number <= next_number + 1'b1;
        end
      end
      if (state == S_AGE && !too_young) begin
        tags[prev_addr] <= '0;
        tags[head_addr] <= MARKER;
        head_idx[tidx] <= slot_inc(head_cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_CHECK: begin
        scan_j <= '0;
        hit <= 1'b0;
        hit_exact <= 1'b0;
        res_status <= ST_DONE;
        res_entry <= '0;
        res_pub <= '0;
        res_photo <= '0;
        res_stamp <= '0;
        if (cmd_r == CMD_PUBLISH || cmd_r == CMD_GET || cmd_r == CMD_EXPIRE) begin
          if (!topic_ok) begin
            res_status <= ST_BADTOPIC;
          end else if (cmd_r == CMD_PUBLISH) begin
            if (ring_full) begin
              res_status <= ST_FULL;
            end else begin
              res_entry <= next_number;
              res_pub <= pub_r;
              res_photo <= photo_r;
              res_stamp <= now_r;
            end
          end else if (ring_empty) begin
            res_status <= ST_EMPTY;
          end
        end
      end
      S_SCAN: begin
        scan_j <= scan_j + 1'b1;
        if (tag_exact) begin
          sel_j <= scan_j;
          hit <= 1'b1;
          hit_exact <= 1'b1;
        end else if (tag_later && !hit) begin
          sel_j <= scan_j;
          hit <= 1'b1;
        end
      end
      S_READ: begin
        if (!hit) begin
          res_status <= ST_NONE;
        end
      end
      S_FETCH: begin
        res_status <= hit_exact ? ST_DONE : ST_LATER;
        res_entry <= tag_rd[NUM_W-1:0];
        res_pub <= mem_rdata.publisher;
        res_photo <= mem_rdata.photo;
        res_stamp <= mem_rdata.stamp;
      end
      S_AGE: begin
        if (too_young) begin
          res_status <= ST_YOUNG;
        end else begin
          res_status <= ST_DONE;
          res_entry <= tag_rd[NUM_W-1:0];
          res_pub <= mem_rdata.publisher;
          res_photo <= mem_rdata.photo;
          res_stamp <= mem_rdata.stamp;
        end
      end
      default: begin
        scan_j <= scan_j;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      status <= res_status;
      entry_num <= res_entry;
      publisher_out <= res_pub;
      photo_out <= res_photo;
      stamp_out <= res_stamp;
    end
  end

endmodule

// ===== tb/sv/topic_ring_queue_with_expiry_unit_test.sv =====
`timescale 1ns / 100ps

module topic_ring_queue_with_expiry_unit_test;
  import trq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] topic;
    logic [NUM_W-1:0] last;
    logic [PUB_W-1:0] pub;
    logic [PHOTO_W-1:0] photo;
    logic [STAMP_W-1:0] now;
  } ring_req_t;

  typedef struct packed {
    status_t status;
    logic [NUM_W-1:0] entry;
    logic [PUB_W-1:0] pub;
    logic [PHOTO_W-1:0] photo;
    logic [STAMP_W-1:0] stamp;
  } ring_reply_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic [1:0] topic = '0;
  logic [NUM_W-1:0] seen_entry = '0;
  logic [PUB_W-1:0] publisher_id = '0;
  logic [PHOTO_W-1:0] photo_ref = '0;
  logic [STAMP_W-1:0] now_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [NUM_W-1:0] entry_num;
  logic [PUB_W-1:0] publisher_out;
  logic [PHOTO_W-1:0] photo_out;
  logic [STAMP_W-1:0] stamp_out;

  topic_ring_queue_with_expiry_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .topic(topic),
    .seen_entry(seen_entry),
    .publisher_id(publisher_id),
    .photo_ref(photo_ref),
    .now_time(now_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .entry_num(entry_num),
    .publisher_out(publisher_out),
    .photo_out(photo_out),
    .stamp_out(stamp_out)
  );

  // Shadow copy of the ring storage and registers.
  logic [TAG_W-1:0] ring_tag [TOTAL_SLOTS];
  logic [STAMP_W-1:0] ring_stamp [TOTAL_SLOTS];
  logic [PUB_W-1:0] ring_pub [TOTAL_SLOTS];
  logic [PHOTO_W-1:0] ring_photo [TOTAL_SLOTS];
  int head_ptr [NUM_TOPICS];
  int tail_ptr [NUM_TOPICS];
  logic [NUM_W-1:0] next_entry;
  logic [AGE_W-1:0] age_limit_r;
  logic [TCOUNT_W-1:0] topic_count_r;

  ring_req_t pend_q [$];
  ring_reply_t expect_q [$];
  ring_req_t cur_req;
  ring_reply_t want_reply;
  int unsigned requested = 0;
  int unsigned answered = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [STAMP_W-1:0] tick_now = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("topic_ring_queue_with_expiry_unit_test: errors");
    $finish;
  end

  function automatic void reset_rings();
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      ring_tag[i] = ((i % SLOTS) == SLOTS - 1) ? MARKER : '0;
      ring_stamp[i] = '0;
      ring_pub[i] = '0;
      ring_photo[i] = '0;
    end
    for (int t = 0; t < NUM_TOPICS; t++) begin
      head_ptr[t] = 0;
      tail_ptr[t] = 0;
    end
    next_entry = NUM_W'(1);
    age_limit_r = AGE_LIMIT_RESET;
    topic_count_r = TOPIC_COUNT_RESET;
  endfunction

  function automatic ring_reply_t slot_reply(input status_t st, input int slot);
    ring_reply_t rp;
    rp.status = st;
    rp.entry = ring_tag[slot][NUM_W-1:0];
    rp.pub = ring_pub[slot];
    rp.photo = ring_photo[slot];
    rp.stamp = ring_stamp[slot];
    return rp;
  endfunction

  function automatic ring_reply_t apply_request(input ring_req_t rq);
    ring_reply_t rp;
    int base, hd, tl, slot;
    longint target;
    logic [STAMP_W-1:0] age;
    rp = '0;
    if (rq.cmd != CMD_PUBLISH && rq.cmd != CMD_GET && rq.cmd != CMD_EXPIRE) return rp;
    if (rq.topic >= topic_count_r || rq.topic >= NUM_TOPICS) begin
      rp.status = ST_BADTOPIC;
      return rp;
    end
    base = int'(rq.topic) * SLOTS;
    hd = head_ptr[rq.topic];
    tl = tail_ptr[rq.topic];
    if (rq.cmd == CMD_PUBLISH) begin
      slot = base + tl;
      if (ring_tag[slot] == MARKER) begin
        rp.status = ST_FULL;
        return rp;
      end
      ring_tag[slot] = {1'b0, next_entry};
      ring_stamp[slot] = rq.now;
      ring_pub[slot] = rq.pub;
      ring_photo[slot] = rq.photo;
      if (next_entry < NUM_MAX) next_entry = next_entry + 1'b1;
      tail_ptr[rq.topic] = (tl + 1) % SLOTS;
      return slot_reply(ST_DONE, slot);
    end
    if (hd == tl) begin
      rp.status = ST_EMPTY;
      return rp;
    end
    if (rq.cmd == CMD_GET) begin
      // The marker ranks as -1 and an empty slot as 0, so neither can ever be picked.
      target = longint'(rq.last) + 1;
      for (int j = 0; j < SLOTS; j++)
        if (longint'($signed(ring_tag[base + j])) == target) return slot_reply(ST_DONE, base + j);
      for (int j = 0; j < SLOTS; j++)
        if (longint'($signed(ring_tag[base + j])) > target) return slot_reply(ST_LATER, base + j);
      rp.status = ST_NONE;
      return rp;
    end
    slot = base + hd;
    age = rq.now - ring_stamp[slot];
    if (age < age_limit_r) begin
      rp.status = ST_YOUNG;
      return rp;
    end
    rp = slot_reply(ST_DONE, slot);
    ring_tag[base + (hd + SLOTS - 1) % SLOTS] = '0;
    ring_tag[slot] = MARKER;
    head_ptr[rq.topic] = (hd + 1) % SLOTS;
    return rp;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at result %0d: %s", answered, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expect_q.push_back(apply_request(cur_req));
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pend_q.pop_front();
          in_valid <= 1'b1;
          cmd <= cur_req.cmd;
          topic <= cur_req.topic;
          seen_entry <= cur_req.last;
          publisher_id <= cur_req.pub;
          photo_ref <= cur_req.photo;
          now_time <= cur_req.now;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want_reply = expect_q.pop_front();
          check_field("status", 32'(status), 32'(want_reply.status));
          check_field("entry_num", 32'(entry_num), 32'(want_reply.entry));
          check_field("publisher_out", 32'(publisher_out), 32'(want_reply.pub));
          check_field("photo_out", photo_out, want_reply.photo);
          check_field("stamp_out", stamp_out, want_reply.stamp);
          answered++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic ring_req_t mk_req(input logic [1:0] c, input logic [1:0] t,
                                       input logic [NUM_W-1:0] l, input logic [PUB_W-1:0] p,
                                       input logic [PHOTO_W-1:0] ph,
                                       input logic [STAMP_W-1:0] n);
    ring_req_t rq;
    rq.cmd = c;
    rq.topic = t;
    rq.last = l;
    rq.pub = p;
    rq.photo = ph;
    rq.now = n;
    return rq;
  endfunction

  task automatic queue_request(input ring_req_t rq);
    pend_q.push_back(rq);
    requested++;
  endtask

  task automatic wait_quiet();
    while (answered != requested) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_AGE_LIMIT) age_limit_r = val[AGE_W-1:0];
    else topic_count_r = val[TCOUNT_W-1:0];
  endtask

  // Mostly legal traffic on the topics in use, with entry numbers near the live ones
  // and a clock that usually creeps forward, plus some noise.
  task automatic add_requests(input int count);
    int pub_w, exp_w, roll;
    longint est, back;
    ring_req_t rq;
    pub_w = $urandom_range(20, 65);
    exp_w = $urandom_range(10, 30);
    est = longint'(next_entry) + pend_q.size();
    for (int j = 0; j < count; j++) begin
      roll = $urandom_range(99);
      if (roll < pub_w) rq.cmd = CMD_PUBLISH;
      else if (roll < pub_w + exp_w) rq.cmd = CMD_EXPIRE;
      else if (roll < 97) rq.cmd = CMD_GET;
      else rq.cmd = CMD_UNUSED;
      if ($urandom_range(99) < 90) rq.topic = 2'($urandom_range(topic_count_r - 1));
      else rq.topic = 2'($urandom_range(3));
      roll = $urandom_range(99);
      if (roll < 85) tick_now = tick_now + $urandom_range(3);
      else if (roll < 95) tick_now = tick_now + $urandom_range(2 * age_limit_r + 2);
      else tick_now = tick_now + $urandom;
      rq.now = ($urandom_range(99) < 95) ? tick_now : $urandom;
      roll = $urandom_range(99);
      if (roll < 5) begin
        rq.last = NUM_W'($urandom);
      end else if (roll < 10) begin
        rq.last = NUM_W'(est + $urandom_range(3));
      end else begin
        back = est - $urandom_range(24);
        if (back < 0) back = 0;
        rq.last = NUM_W'(back);
      end
      rq.pub = PUB_W'($urandom);
      rq.photo = $urandom;
      if (rq.cmd == CMD_PUBLISH) est++;
      queue_request(rq);
    end
  endtask

  initial begin
    logic [AGE_W-1:0] age_v;
    logic [TCOUNT_W-1:0] count_v;
    int idle_v, stall_v;
    reset_rings();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_request(mk_req(CMD_GET, 2'd0, '0, '0, '0, '0));
    queue_request(mk_req(CMD_EXPIRE, 2'd0, '0, '0, '0, '0));
    queue_request(mk_req(CMD_PUBLISH, 2'd3, '0, 16'h1234, 32'h1, 32'd7));
    queue_request(mk_req(CMD_UNUSED, 2'd3, '1, '1, '1, '1));
    for (int k = 0; k < SLOTS - 1; k++)
      queue_request(mk_req(CMD_PUBLISH, 2'd0, '0, k[0] ? '1 : '0, k[0] ? '1 : '0, 32'd100));
    queue_request(mk_req(CMD_PUBLISH, 2'd0, '0, 16'h5a5a, 32'h5a5a5a5a, 32'd101));
    queue_request(mk_req(CMD_GET, 2'd0, '0, '0, '0, '0));
    queue_request(mk_req(CMD_GET, 2'd0, '1, '0, '0, '0));
    queue_request(mk_req(CMD_GET, 2'd0, 31'd3, '0, '0, '0));
    queue_request(mk_req(CMD_EXPIRE, 2'd0, '0, '0, '0, 32'd104));
    queue_request(mk_req(CMD_EXPIRE, 2'd0, '0, '0, '0, 32'd105));
    queue_request(mk_req(CMD_GET, 2'd0, '0, '0, '0, '0));
    queue_request(mk_req(CMD_PUBLISH, 2'd1, '0, 16'h00ff, 32'hff00ff00, 32'hfffffffe));
    queue_request(mk_req(CMD_EXPIRE, 2'd1, '0, '0, '0, 32'd3));
    queue_request(mk_req(CMD_PUBLISH, 2'd2, '0, 16'hff00, 32'h00ff00ff, 32'hffffffff));
    queue_request(mk_req(CMD_EXPIRE, 2'd2, '0, '0, '0, 32'd0));
    queue_request(mk_req(CMD_GET, 2'd1, 31'd5, '0, '0, '0));
    wait_quiet();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          age_v = '0; count_v = 3'd4; idle_v = 0; stall_v = 0;
        end
        1: begin
          age_v = '1; count_v = 3'd1; idle_v = 84; stall_v = 0;
        end
        2: begin
          age_v = AGE_W'($urandom_range(1, 60)); count_v = 3'd2; idle_v = 0; stall_v = 84;
        end
        default: begin
          age_v = 16'd12; count_v = 3'd3; idle_v = 13; stall_v = 13;
        end
      endcase
      write_reg(REG_AGE_LIMIT, age_v);
      write_reg(REG_TOPIC_COUNT, CFG_W'(count_v));
      send_idle_pct = idle_v;
      recv_stall_pct = stall_v;
      tick_now = $urandom;
      for (int c = 0; c < 18; c++) begin
        while (pend_q.size() >= 4) @(posedge clk);
        add_requests(25);
      end
      wait_quiet();
    end

    repeat (SLOTS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("topic_ring_queue_with_expiry_unit_test: clean");
    end else begin
      $display("topic_ring_queue_with_expiry_unit_test: errors");
    end
    $finish;
  end

endmodule

// ===== topic_ring_queue_with_expiry_unit.f =====
hw/rtl/trq_pkg.sv
hw/rtl/trq_slot_mem.sv
hw/rtl/topic_ring_queue_with_expiry_unit.sv
tb/sv/topic_ring_queue_with_expiry_unit_test.sv
